// ===== rtl/rectangle_union_area_assert.svh =====
// Assertion macros shared by the rectangle union area RTL.
`ifndef RECTANGLE_UNION_AREA_ASSERT_SVH
`define RECTANGLE_UNION_AREA_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is held.
`define RUA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define RUA_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RUA_ASSERT(lbl, prop, msg)
`define RUA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== rtl/rua_pkg.sv =====
// Shared types, codes and helpers for the rectangle union area block.
`timescale 1ns / 1ps
package rua_pkg;

    localparam int WORD_BITS = 64;
    localparam int LANE_BITS = 6;
    localparam int COORD_W   = 9;
    localparam int AREA_W    = 17;
    localparam int CNT_W     = 7;

    // most cells one word can add
    localparam logic [CNT_W-1:0] WORD_CNT = 7'd64;

    // item kinds
    localparam logic KIND_PAINT = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_PAINT,
        ST_CLEAR
    } t_state;

    // controller to walker
    typedef struct packed {
        logic load;
        logic clr;
    } t_walk_cmd;

    // walker to coverage memory
    typedef struct packed {
        logic vld;
        logic clr;
    } t_mem_req;

    // newly covered cells of one word
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] cnt;
    } t_cnt_beat;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'b000, b[i]};
        end
        return c;
    endfunction

endpackage

// ===== rtl/rua_walker.sv =====
// Address walker: steps rows and words of a rectangle, or sweeps the whole store.
`timescale 1ns / 1ps
module rua_walker #(
    parameter int GRID_SIDE = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  rua_pkg::t_walk_cmd                      i_cmd,
    input  logic signed [rua_pkg::COORD_W-1:0]      i_x_low,
    input  logic signed [rua_pkg::COORD_W-1:0]      i_y_low,
    input  logic signed [rua_pkg::COORD_W-1:0]      i_x_high,
    input  logic signed [rua_pkg::COORD_W-1:0]      i_y_high,
    output rua_pkg::t_mem_req                       o_req,
    output logic [$clog2(GRID_SIDE)+((((GRID_SIDE+63)/64) > 1) ?
                  $clog2((GRID_SIDE+63)/64) : 1)-1:0] o_addr,
    output logic [rua_pkg::WORD_BITS-1:0]           o_mask,
    output logic                                    o_busy
);

    localparam int ROW_WORDS = (GRID_SIDE + 63) / 64;
    localparam int W_BITS    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int XW        = $clog2(GRID_SIDE);
    localparam int CW        = $clog2(GRID_SIDE + 1);
    localparam int EW        = ((CW > rua_pkg::COORD_W) ? CW : rua_pkg::COORD_W) + 2;
    localparam int LB        = rua_pkg::LANE_BITS;
    localparam int YE        = LB + W_BITS;

    // offset to cell edge and saturate to the grid
    function automatic logic [CW-1:0] to_edge(
        input logic signed [rua_pkg::COORD_W-1:0] v
    );
        logic signed [EW-1:0] s;
        s = EW'(v) + EW'(GRID_SIDE / 2);
        if (s < 0) begin
            return '0;
        end else if (s > EW'(GRID_SIDE)) begin
            return CW'(GRID_SIDE);
        end
        return s[CW-1:0];
    endfunction

    logic [XW-1:0]     r_x;
    logic [XW-1:0]     r_xlast;
    logic [W_BITS-1:0] r_w;
    logic [W_BITS-1:0] r_wl;
    logic [W_BITS-1:0] r_wh;
    logic [LB-1:0]     r_lo;
    logic [LB-1:0]     r_hi;
    logic              r_clr;
    logic              r_busy;

    logic [CW-1:0] xl, xh, yl, yh, xh_m1, yh_m1;
    logic [YE-1:0] y_first, y_last;
    logic          empty;

    // clamped edges of the incoming rectangle
    always_comb begin
        xl      = to_edge(i_x_low);
        yl      = to_edge(i_y_low);
        xh      = to_edge(i_x_high);
        yh      = to_edge(i_y_high);
        xh_m1   = xh - CW'(1);
        yh_m1   = yh - CW'(1);
        y_first = YE'(yl);
        y_last  = YE'(yh_m1);
        empty   = (xh <= xl) || (yh <= yl);
    end

    // walk state: word inner, row outer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.load && i_cmd.clr)) begin
            r_x     <= '0;
            r_xlast <= XW'(GRID_SIDE - 1);
            r_w     <= '0;
            r_wl    <= '0;
            r_wh    <= W_BITS'(ROW_WORDS - 1);
            r_lo    <= '0;
            r_hi    <= '1;
            r_clr   <= 1'b1;
            r_busy  <= 1'b1;
        end else if (i_cmd.load) begin
            r_x     <= xl[XW-1:0];
            r_xlast <= xh_m1[XW-1:0];
            r_w     <= y_first[YE-1:LB];
            r_wl    <= y_first[YE-1:LB];
            r_wh    <= y_last[YE-1:LB];
            r_lo    <= y_first[LB-1:0];
            r_hi    <= y_last[LB-1:0];
            r_clr   <= 1'b0;
            r_busy  <= !empty;
        end else if (r_busy) begin
            if (r_w == r_wh) begin
                r_w <= r_wl;
                if (r_x == r_xlast) begin
                    r_busy <= 1'b0;
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end else begin
                r_w <= r_w + W_BITS'(1);
            end
        end
    end

    logic [LB-1:0] lo_bit, hi_bit;

    // cell mask of the current word
    always_comb begin
        lo_bit = (r_w == r_wl) ? r_lo : '0;
        hi_bit = (r_w == r_wh) ? r_hi : '1;
        o_mask = ({rua_pkg::WORD_BITS{1'b1}} << lo_bit)
               & ({rua_pkg::WORD_BITS{1'b1}} >> (~hi_bit));
    end

    assign o_req.vld = r_busy;
    assign o_req.clr = r_clr;
    assign o_addr    = {r_x, r_w};
    assign o_busy    = r_busy;

endmodule

// ===== rtl/rua_cov_mem.sv =====
// Coverage memory with read-modify-write pipeline and per-word fresh-cell count.
`timescale 1ns / 1ps
`include "rectangle_union_area_assert.svh"
module rua_cov_mem #(
    parameter int GRID_SIDE = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  rua_pkg::t_mem_req                       i_req,
    input  logic [$clog2(GRID_SIDE)+((((GRID_SIDE+63)/64) > 1) ?
                  $clog2((GRID_SIDE+63)/64) : 1)-1:0] i_addr,
    input  logic [rua_pkg::WORD_BITS-1:0]           i_mask,
    output rua_pkg::t_cnt_beat                      o_beat,
    output logic                                    o_busy
);

    localparam int ROW_WORDS = (GRID_SIDE + 63) / 64;
    localparam int W_BITS    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int XW        = $clog2(GRID_SIDE);
    localparam int AW        = XW + W_BITS;
    localparam int DEPTH     = GRID_SIDE * (2 ** W_BITS);
    localparam int WB        = rua_pkg::WORD_BITS;
    localparam int NBYTES    = WB / 8;

    logic [WB-1:0] mem [DEPTH];

    logic [WB-1:0]            r_rdata;
    logic                     r_s1_vld;
    logic [AW-1:0]            r_s1_addr;
    logic [WB-1:0]            r_s1_mask;
    logic                     r_s2_vld;
    logic [3:0]               r_s2_pc [NBYTES];
    logic                     r_s3_vld;
    logic [rua_pkg::CNT_W-1:0] r_s3_cnt;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WB-1:0] wr_data;
    logic [WB-1:0] fresh;

    // single write port: write-back of stage 1, or zero fill during a sweep
    always_comb begin
        wr_en   = r_s1_vld || (i_req.vld && i_req.clr);
        wr_addr = r_s1_vld ? r_s1_addr : i_addr;
        wr_data = r_s1_vld ? (r_rdata | r_s1_mask) : '0;
        fresh   = r_s1_mask & ~r_rdata;
    end

    // storage, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[i_addr];
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.vld && !i_req.clr;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    logic [rua_pkg::CNT_W-1:0] sum;

    // byte counts, then their sum
    always_comb begin
        sum = '0;
        for (int i = 0; i < NBYTES; i++) begin
            sum = sum + {3'b000, r_s2_pc[i]};
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_addr;
        r_s1_mask <= i_mask;
        for (int i = 0; i < NBYTES; i++) begin
            r_s2_pc[i] <= rua_pkg::popcount8(fresh[i*8 +: 8]);
        end
        r_s3_cnt <= sum;
    end

    assign o_beat.vld = r_s3_vld;
    assign o_beat.cnt = r_s3_cnt;
    assign o_busy     = r_s1_vld || r_s2_vld || r_s3_vld;

    // a write-back never meets a read of the same word
    `RUA_ASSERT(a_no_rmw_overlap, (r_s1_vld && i_req.vld) |-> (r_s1_addr != i_addr), "read meets pending write-back")
    // a sweep never runs over paint beats
    `RUA_ASSERT(a_clear_alone, (i_req.vld && i_req.clr) |-> !(r_s1_vld || r_s2_vld || r_s3_vld), "sweep overlaps paint pipeline")
    // one word adds at most one word of cells
    `RUA_ASSERT(a_cnt_bound, r_s3_vld |-> (r_s3_cnt <= rua_pkg::WORD_CNT), "fresh count above word size")

endmodule

// ===== rtl/rectangle_union_area.sv =====
// Paint item: one memory word per cycle over the rows x words touched; the result strobe follows
// once the walker and the memory pipeline are idle. An empty rectangle answers without memory access.
// Clear item: zero sweep of GRID_SIDE * ceil(GRID_SIDE/64) words, then the result strobe.
// One item at a time: busy rises after acceptance and falls as the result strobe goes high.
// Reset (synchronous, active low) starts the same sweep, with no result.
`timescale 1ns / 1ps
`include "rectangle_union_area_assert.svh"
module rectangle_union_area #(
    parameter int GRID_SIDE = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_kind,
    input  logic signed [rua_pkg::COORD_W-1:0] i_x_low,
    input  logic signed [rua_pkg::COORD_W-1:0] i_y_low,
    input  logic signed [rua_pkg::COORD_W-1:0] i_x_high,
    input  logic signed [rua_pkg::COORD_W-1:0] i_y_high,
    output logic                               o_done,
    output logic [rua_pkg::AREA_W-1:0]         o_area
);

    localparam int ROW_WORDS = (GRID_SIDE + 63) / 64;
    localparam int W_BITS    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int AW        = $clog2(GRID_SIDE) + W_BITS;

    rua_pkg::t_state    r_state, n_state;
    rua_pkg::t_walk_cmd walk_cmd;
    rua_pkg::t_mem_req  mem_req;
    rua_pkg::t_cnt_beat cnt_beat;

    logic [AW-1:0]                   mem_addr;
    logic [rua_pkg::WORD_BITS-1:0]   mem_mask;
    logic                            walk_busy;
    logic                            pipe_busy;
    logic                            accept;
    logic                            n_done;
    logic                            r_done;
    logic [rua_pkg::AREA_W-1:0]      r_area;

    rua_walker #(
        .GRID_SIDE (GRID_SIDE)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (walk_cmd),
        .i_x_low  (i_x_low),
        .i_y_low  (i_y_low),
        .i_x_high (i_x_high),
        .i_y_high (i_y_high),
        .o_req    (mem_req),
        .o_addr   (mem_addr),
        .o_mask   (mem_mask),
        .o_busy   (walk_busy)
    );

    rua_cov_mem #(
        .GRID_SIDE (GRID_SIDE)
    ) u_cov_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .i_addr  (mem_addr),
        .i_mask  (mem_mask),
        .o_beat  (cnt_beat),
        .o_busy  (pipe_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rua_pkg::ST_INIT: begin
                n_state = walk_busy ? rua_pkg::ST_INIT : rua_pkg::ST_IDLE;
            end
            rua_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_kind == rua_pkg::KIND_PAINT) ? rua_pkg::ST_PAINT
                                                              : rua_pkg::ST_CLEAR;
                end
            end
            rua_pkg::ST_PAINT: begin
                if (!walk_busy && !pipe_busy) begin
                    n_state = rua_pkg::ST_IDLE;
                end
            end
            rua_pkg::ST_CLEAR: begin
                if (!walk_busy) begin
                    n_state = rua_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // controller outputs
    always_comb begin
        busy         = (r_state != rua_pkg::ST_IDLE);
        accept       = start && !busy;
        walk_cmd.load = accept;
        walk_cmd.clr  = (i_kind == rua_pkg::KIND_CLEAR);
        n_done       = ((r_state == rua_pkg::ST_PAINT) && !walk_busy && !pipe_busy)
                    || ((r_state == rua_pkg::ST_CLEAR) && !walk_busy);
    end

    // state, strobe and running area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rua_pkg::ST_INIT;
            r_done  <= 1'b0;
            r_area  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (accept && (i_kind == rua_pkg::KIND_CLEAR)) begin
                r_area <= '0;
            end else if (cnt_beat.vld) begin
                r_area <= r_area
                        + {{(rua_pkg::AREA_W - rua_pkg::CNT_W){1'b0}}, cnt_beat.cnt};
            end
        end
    end

    assign o_done = r_done;
    assign o_area = r_area;

    // nothing in flight once idle
    `RUA_ASSERT(a_idle_drained, (r_state == rua_pkg::ST_IDLE) |-> (!walk_busy && !pipe_busy), "idle with work in flight")
    // result strobe is a single beat
    `RUA_ASSERT_NR(a_done_single, o_done |=> !o_done, "result strobe longer than one cycle")
    // a clear item zeroes the area at once
    `RUA_ASSERT(a_clear_zero, (accept && (i_kind == rua_pkg::KIND_CLEAR)) |=> (o_area == '0), "area not zeroed by clear")

endmodule

// ===== tb/rectangle_union_area_test.sv =====
// Self-checking testbench for the rectangle union area block.
`timescale 1ns / 1ps
module rectangle_union_area_test;

    localparam int GRID_SIDE    = 256;
    localparam int RANDOM_ITEMS = 558;
    localparam int DRAIN_CYCLES = 40;
    // reset sweep plus every item as a full-grid paint with the longest gap, four times over
    localparam int CYCLE_LIMIT  = 2_500_000;

    typedef logic signed [rua_pkg::COORD_W-1:0] t_coord;

    // Tracks the coverage bitmap and the running union area
    class union_tracker;
        bit [GRID_SIDE-1:0]         cover_rows [GRID_SIDE];
        int unsigned                cells_marked;
        logic [rua_pkg::AREA_W-1:0] areas_due [$];
        int unsigned                failures;

        // signed edge to cell edge, saturated onto the grid
        function int clamp_edge(t_coord v);
            int c;
            c = int'(v) + GRID_SIDE / 2;
            if (c < 0) c = 0;
            if (c > GRID_SIDE) c = GRID_SIDE;
            return c;
        endfunction

        // accepted input beat: update the bitmap and queue the area it yields
        function void note_item(logic kind, t_coord xl_f, t_coord yl_f,
                                t_coord xh_f, t_coord yh_f);
            int                 xl, yl, xh, yh;
            bit [GRID_SIDE:0]   hi_m, lo_m;
            bit [GRID_SIDE-1:0] span, fresh;
            if (kind == rua_pkg::KIND_CLEAR) begin
                foreach (cover_rows[r]) cover_rows[r] = '0;
                cells_marked = 0;
            end else begin
                xl = clamp_edge(xl_f);
                yl = clamp_edge(yl_f);
                xh = clamp_edge(xh_f);
                yh = clamp_edge(yh_f);
                // column mask of cells yl .. yh-1; empty when yh <= yl
                hi_m = (GRID_SIDE + 1)'(1);
                hi_m = (hi_m << yh) - 1'b1;
                lo_m = (GRID_SIDE + 1)'(1);
                lo_m = (lo_m << yl) - 1'b1;
                span = hi_m[GRID_SIDE-1:0] & ~lo_m[GRID_SIDE-1:0];
                for (int x = xl; x < xh; x++) begin
                    fresh = span & ~cover_rows[x];
                    cells_marked += $countones(fresh);
                    cover_rows[x] |= span;
                end
            end
            areas_due.push_back(cells_marked[rua_pkg::AREA_W-1:0]);
        endfunction

        // result beat against the oldest expected area
        function void check_area(logic [rua_pkg::AREA_W-1:0] actual);
            logic [rua_pkg::AREA_W-1:0] want;
            if (areas_due.size() == 0) begin
                $error("area: unexpected result, actual %0d", actual);
                failures++;
            end else begin
                want = areas_due.pop_front();
                if (actual !== want) begin
                    $error("area mismatch: expected %0d, actual %0d", want, actual);
                    failures++;
                end
            end
        endfunction

        function int unsigned pending();
            return areas_due.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_kind;
    t_coord                     i_x_low;
    t_coord                     i_y_low;
    t_coord                     i_x_high;
    t_coord                     i_y_high;
    logic                       o_done;
    logic [rua_pkg::AREA_W-1:0] o_area;

    union_tracker tracker = new();
    int           idle_style;
    int unsigned  cycle_count;

    rectangle_union_area #(
        .GRID_SIDE(GRID_SIDE)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_x_low (i_x_low),
        .i_y_low (i_y_low),
        .i_x_high(i_x_high),
        .i_y_high(i_y_high),
        .o_done  (o_done),
        .o_area  (o_area)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rectangle_union_area_test: errors");
            $finish;
        end
    end

    // result beats, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            tracker.check_area(o_area);
        end
    end

    // gap before the next beat, by the current idling style
    function automatic int pick_gap();
        case (idle_style)
            0: return 0;
            1: return $urandom_range(0, 14);
            default: return $urandom_range(0, 1);
        endcase
    endfunction

    // one input beat; called at a falling edge, returns at a falling edge
    task automatic send_item(input logic kind, input t_coord xl, input t_coord yl,
                             input t_coord xh, input t_coord yh);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start    = 1'b1;
        i_kind   = kind;
        i_x_low  = xl;
        i_y_low  = yl;
        i_x_high = xh;
        i_y_high = yh;
        do @(posedge i_clk); while (busy);
        tracker.note_item(kind, xl, yl, xh, yh);
        @(negedge i_clk);
    endtask

    task automatic paint(input int xl, input int yl, input int xh, input int yh);
        send_item(rua_pkg::KIND_PAINT, t_coord'(xl), t_coord'(yl), t_coord'(xh),
                  t_coord'(yh));
    endtask

    initial begin
        t_coord xl, yl, xh, yh;
        int     pick;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_kind     = rua_pkg::KIND_PAINT;
        i_x_low    = '0;
        i_y_low    = '0;
        i_x_high   = '0;
        i_y_high   = '0;
        idle_style = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, saturation, empty shapes, word boundaries, clears
        paint(-128, -128, 128, 128);
        paint(-128, -128, 128, 128);
        send_item(rua_pkg::KIND_CLEAR, '0, '0, '0, '0);
        paint(-256, -256, 255, 255);
        send_item(rua_pkg::KIND_CLEAR, '1, '1, '1, '1);
        paint(-128, -128, -127, -127);
        paint(127, 127, 128, 128);
        paint(10, -65, 11, -63);
        paint(-5, -1, 5, 1);
        paint(0, 0, 0, 10);
        paint(0, 0, 10, 0);
        paint(20, 20, -20, -20);
        paint(-256, -256, -200, -200);
        paint(200, 200, 255, 255);
        paint(-200, 0, -120, 8);
        paint(100, 100, 200, 200);
        paint(-10, -10, 10, 10);
        paint(-128, -1, 128, 0);
        paint(-1, -128, 0, 128);
        send_item(rua_pkg::KIND_CLEAR, '0, '0, '0, '0);
        paint(0, -32, 1, 96);
        paint(255, -256, -256, 255);

        // random: mostly small overlapping rectangles, some large, empty and clear beats
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) idle_style = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                xl = t_coord'($urandom);
                yl = t_coord'($urandom);
                xh = t_coord'($urandom);
                yh = t_coord'($urandom);
                send_item(rua_pkg::KIND_CLEAR, xl, yl, xh, yh);
            end else if (pick < 10) begin
                // high edge not above low edge on one axis
                xl = t_coord'($urandom_range(0, 280) - 140);
                yl = t_coord'($urandom_range(0, 280) - 140);
                if (pick[0]) begin
                    xh = t_coord'(xl - $urandom_range(0, 20));
                    yh = t_coord'(yl + $urandom_range(0, 30));
                end else begin
                    xh = t_coord'(xl + $urandom_range(0, 30));
                    yh = t_coord'(yl - $urandom_range(0, 20));
                end
                send_item(rua_pkg::KIND_PAINT, xl, yl, xh, yh);
            end else if (pick < 15) begin
                // any 9-bit edges, often large or off the grid
                xl = t_coord'($urandom);
                yl = t_coord'($urandom);
                xh = t_coord'($urandom);
                yh = t_coord'($urandom);
                send_item(rua_pkg::KIND_PAINT, xl, yl, xh, yh);
            end else begin
                xl = t_coord'($urandom_range(0, 280) - 140);
                yl = t_coord'($urandom_range(0, 280) - 140);
                xh = t_coord'(xl + $urandom_range(1, 24));
                yh = t_coord'(yl + $urandom_range(1, 24));
                send_item(rua_pkg::KIND_PAINT, xl, yl, xh, yh);
            end
        end
        start = 1'b0;

        // drain outstanding results
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0) begin
            $display("rectangle_union_area_test: clean");
        end else begin
            $display("rectangle_union_area_test: errors");
        end
        $finish;
    end

endmodule

// ===== rectangle_union_area.f =====
+incdir+rtl
rtl/rua_pkg.sv
rtl/rua_walker.sv
rtl/rua_cov_mem.sv
rtl/rectangle_union_area.sv
tb/rectangle_union_area_test.sv
